/* rtl/core/beat_nod_burst_sequencer_macros.svh */
// Assertion macros shared by the beat nod burst sequencer RTL.
// Depends on nothing; take it in with a plain include.
`ifndef BEAT_NOD_BURST_SEQUENCER_MACROS_SVH
`define BEAT_NOD_BURST_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BNBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BNBS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bnbs_pkg.sv */
// Types, codes and constants of the beat nod burst sequencer.
// Depends on nothing; the top level imports it.
package bnbs_pkg;

  // Neck travel in servo steps for the full angle window (position 0 down to -100).
  localparam int unsigned POS_SPAN = 100;

  localparam int unsigned ANG_LO    = 170;
  localparam int unsigned ANG_HI    = 800;
  localparam int unsigned ANG_WIN   = ANG_HI - ANG_LO;
  localparam int unsigned ANG_DIF_W = $clog2(ANG_WIN + 1);
  localparam int unsigned FPS       = 23;
  localparam int unsigned PARK_ANGLE = ANG_LO + 30;

  localparam int unsigned MIN_RUN     = 10 * FPS;
  localparam int unsigned RUN_JITTER  = 8 * FPS;
  localparam int unsigned END_GRACE   = 2 * FPS;
  localparam int unsigned WAIT_MIN    = 8 * FPS;
  localparam int unsigned WAIT_JITTER = 12 * FPS;
  localparam int unsigned PATIENCE    = 2 * FPS;

  localparam logic [15:0] LFSR_SEED   = 16'hBEEF;
  localparam logic [15:0] ARMED_MAX   = 16'hFFFF;
  localparam logic [9:0]  QUIET_MAX   = 10'd1023;
  localparam logic [6:0]  CONF_MAX    = 7'd100;
  localparam logic [6:0]  FLOOR_RESET = 7'd30;
  localparam logic [9:0]  IDLE_RESET  = 10'd750;
  localparam int unsigned LOUD_GAIN   = 39;

  // Angle scaled by POS_SPAN, then divided by the window through a reciprocal.
  localparam int unsigned SCALED_W  = $clog2(ANG_WIN * POS_SPAN + 1);
  localparam int unsigned MAP_SHIFT = SCALED_W + ANG_DIF_W;
  localparam longint unsigned MAP_RECIP =
      ((64'd1 << MAP_SHIFT) + ANG_WIN - 1) / ANG_WIN;
  localparam int unsigned MAP_RECIP_W = $clog2(MAP_RECIP + 1);
  localparam int unsigned MAP_PROD_W  = SCALED_W + MAP_RECIP_W;

  // Remainders of the 16-bit LFSR word by the two jitter spans.
  localparam int unsigned RUN_SHIFT = 16 + $clog2(RUN_JITTER);
  localparam longint unsigned RUN_RECIP =
      ((64'd1 << RUN_SHIFT) + RUN_JITTER - 1) / RUN_JITTER;
  localparam int unsigned RUN_RECIP_W = $clog2(RUN_RECIP + 1);
  localparam int unsigned WAIT_SHIFT = 16 + $clog2(WAIT_JITTER);
  localparam longint unsigned WAIT_RECIP =
      ((64'd1 << WAIT_SHIFT) + WAIT_JITTER - 1) / WAIT_JITTER;
  localparam int unsigned WAIT_RECIP_W = $clog2(WAIT_RECIP + 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_NOD_MODE   = 2'd0;
  localparam logic [1:0] REG_CONF_FLOOR = 2'd1;
  localparam logic [1:0] REG_IDLE_PARK  = 2'd2;

  // Modes.
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_ALWAYS = 2'd1;
  localparam logic [1:0] MODE_AUTO   = 2'd2;
  localparam logic [1:0] MODE_BAD    = 2'd3;

  // Item kinds.
  localparam logic FUNC_FRAME = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Beat strengths.
  localparam logic [1:0] STR_NONE   = 2'd0;
  localparam logic [1:0] STR_ONSET  = 2'd1;
  localparam logic [1:0] STR_STRONG = 2'd2;

  // Reported burst state codes.
  localparam logic [1:0] BS_WAITING   = 2'd0;
  localparam logic [1:0] BS_NODDING   = 2'd1;
  localparam logic [1:0] BS_FINISHING = 2'd2;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'b001,
    PH_NOD    = 3'b010,
    PH_FINISH = 3'b100
  } bnbs_phase_t;

  typedef struct packed {
    logic       func;
    logic [7:0] energy;
    logic       bass_onset;
    logic       mid_onset;
    logic       big_beat;
    logic [6:0] confidence;
    logic       full_band_wins;
    logic [9:0] target_angle;
  } bnbs_in_t;

  typedef struct packed {
    logic              servo_write;
    logic signed [7:0] neck_position;
    logic [1:0]        bass_strength;
    logic [1:0]        full_strength;
    logic [13:0]       loudness;
    logic [1:0]        burst_state;
    logic [8:0]        frames_into_burst;
    logic [8:0]        burst_length;
    logic [8:0]        frames_to_wait;
    logic [15:0]       beats_in_burst;
    logic [6:0]        peak_confidence;
    logic [31:0]       bursts_started;
  } bnbs_out_t;

endpackage

/* rtl/core/beat_nod_burst_sequencer.sv */
// Beat nod burst sequencer: neck servo command from tempo engine frames and ms ticks.
// Depends on bnbs_pkg and beat_nod_burst_sequencer_macros.svh.
//
//   port group   direction   flow control     carries
//   in_*         in          in_vld/in_stall  one frame or tick (bnbs_in_t)
//   out_*        out         out_vld/out_stall one result (bnbs_out_t)
//   cfg_*        in          cfg_we only      register writes, index 0..2
//
// Two register stages: an input register (angle scaling, loudness) and a result
// register (sequencer step, position divide, LFSR jitter remainder).
// One item per cycle sustained unless out_stall holds a result; the input register can
// still take one item while a result waits to be taken, then in_stall rises.
// rst_n is synchronous; control and sequencer state reset, payloads do not.
`include "beat_nod_burst_sequencer_macros.svh"

module beat_nod_burst_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  output logic              in_stall,
  input  bnbs_pkg::bnbs_in_t  in_data,
  output logic              out_vld,
  input  logic              out_stall,
  output bnbs_pkg::bnbs_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [9:0]        cfg_wdata
);
  import bnbs_pkg::*;

  // Pipeline control and payload
  logic                in_vld_r;
  bnbs_in_t            item_r;
  logic [SCALED_W-1:0] scaled_r;
  logic [13:0]         loud_r;
  logic                out_vld_r;
  bnbs_out_t           out_data_r;
  bnbs_out_t           out_nxt;
  logic                advance;
  logic                in_take;

  // Configuration
  logic [1:0] mode_r;
  logic [6:0] floor_r;
  logic [9:0] idle_r;

  // Sequencer state
  logic [15:0]       lfsr_r, lfsr_nxt;
  bnbs_phase_t       phase_r, phase_nxt;
  logic [8:0]        wait_r, wait_nxt;
  logic [15:0]       armed_r, armed_nxt;
  logic [8:0]        runf_r, runf_nxt;
  logic [8:0]        runt_r, runt_nxt;
  logic [15:0]       runb_r, runb_nxt;
  logic [31:0]       total_r, total_nxt;
  logic [6:0]        peak_r, peak_nxt;
  logic              parked_r, parked_nxt;
  logic [9:0]        quiet_r, quiet_nxt;
  logic signed [7:0] pos_r, pos_nxt;

  // Stage one datapath
  logic [ANG_DIF_W-1:0] ang_dif;
  logic [9:0]           ang_clamp;

  // Stage two datapath
  logic [15:0]               lfsr_mix;
  logic [15:0]               lfsr_step;
  logic [16+RUN_RECIP_W-1:0]  run_prod;
  logic [16+WAIT_RECIP_W-1:0] wait_prod;
  logic [8:0]                run_quo, wait_quo;
  logic [8:0]                run_rem, wait_rem;
  logic [MAP_PROD_W-1:0]     map_prod;
  logic [7:0]                map_quo;
  logic signed [7:0]         map_pos;
  logic [1:0]                bs, fs;
  logic                      beat;
  logic                      follow;
  logic                      write;
  logic [1:0]                cfg_mode;
  logic [6:0]                cfg_floor;

  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_vld && !in_stall;
  assign out_vld  = out_vld_r;
  assign out_data = out_data_r;

  // Clamp and scale the angle on the way in.
  always_comb begin
    if (in_data.target_angle < 10'(ANG_LO)) begin
      ang_clamp = 10'(ANG_LO);
    end else if (in_data.target_angle > 10'(ANG_HI)) begin
      ang_clamp = 10'(ANG_HI);
    end else begin
      ang_clamp = in_data.target_angle;
    end
    ang_dif = ANG_DIF_W'(ang_clamp - 10'(ANG_LO));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r   <= in_data;
      scaled_r <= SCALED_W'(ang_dif * POS_SPAN);
      loud_r   <= 14'(in_data.energy * LOUD_GAIN);
    end
  end

  // LFSR stirred by the frame energy; a zero word restarts from the seed.
  always_comb begin
    lfsr_mix = lfsr_r ^ {8'h00, item_r.energy};
    if (lfsr_mix == 16'h0000) begin
      lfsr_mix = LFSR_SEED;
    end
    lfsr_step = {lfsr_mix[0] ^ lfsr_mix[2] ^ lfsr_mix[3] ^ lfsr_mix[5], lfsr_mix[15:1]};
  end

  // Jitter remainders through reciprocal multiply, then subtract quotient times span.
  always_comb begin
    run_prod  = (16+RUN_RECIP_W)'(lfsr_step) * (16+RUN_RECIP_W)'(RUN_RECIP);
    wait_prod = (16+WAIT_RECIP_W)'(lfsr_step) * (16+WAIT_RECIP_W)'(WAIT_RECIP);
    run_quo   = run_prod[RUN_SHIFT +: 9];
    wait_quo  = wait_prod[WAIT_SHIFT +: 9];
    run_rem   = 9'(lfsr_step - 16'(run_quo * RUN_JITTER));
    wait_rem  = 9'(lfsr_step - 16'(wait_quo * WAIT_JITTER));
  end

  // Position: scaled angle over the window, negated.
  always_comb begin
    map_prod = MAP_PROD_W'(scaled_r) * MAP_PROD_W'(MAP_RECIP);
    map_quo  = {1'b0, map_prod[MAP_SHIFT +: 7]};
    map_pos  = 8'sd0 - $signed(map_quo);
  end

  always_comb begin
    lfsr_nxt   = lfsr_r;
    phase_nxt  = phase_r;
    wait_nxt   = wait_r;
    armed_nxt  = armed_r;
    runf_nxt   = runf_r;
    runt_nxt   = runt_r;
    runb_nxt   = runb_r;
    total_nxt  = total_r;
    peak_nxt   = peak_r;
    parked_nxt = parked_r;
    quiet_nxt  = quiet_r;
    pos_nxt    = pos_r;
    write      = 1'b0;
    follow     = 1'b0;
    bs         = STR_NONE;
    fs         = STR_NONE;
    beat       = 1'b0;
    cfg_mode   = (cfg_wdata[1:0] == MODE_BAD) ? MODE_OFF : cfg_wdata[1:0];
    cfg_floor  = (cfg_wdata[6:0] > CONF_MAX) ? CONF_MAX : cfg_wdata[6:0];

    if (advance) begin
      if (item_r.func == FUNC_TICK) begin
        if (quiet_r != QUIET_MAX) begin
          quiet_nxt = quiet_r + 10'd1;
        end
        // Park after the quiet timeout unless the mode is off or the neck is already parked.
        if (mode_r != MODE_OFF && !parked_r && quiet_nxt >= idle_r) begin
          pos_nxt    = 8'sd0;
          parked_nxt = 1'b1;
          write      = 1'b1;
          phase_nxt  = PH_WAIT;
          wait_nxt   = 9'd0;
        end
      end else begin
        quiet_nxt = 10'd0;
        if (item_r.bass_onset) begin
          bs = item_r.big_beat ? STR_STRONG : STR_ONSET;
        end
        if (item_r.mid_onset) begin
          fs = item_r.big_beat ? STR_STRONG : STR_ONSET;
        end
        beat = item_r.full_band_wins ? item_r.mid_onset : item_r.bass_onset;

        if (mode_r == MODE_AUTO) begin
          if (item_r.confidence > peak_r) begin
            peak_nxt = item_r.confidence;
          end
          if (phase_r == PH_WAIT) begin
            if (wait_r != 9'd0) begin
              wait_nxt  = wait_r - 9'd1;
              armed_nxt = 16'd0;
            end else if (item_r.confidence < floor_r) begin
              armed_nxt = 16'd0;
            end else begin
              if (armed_r != ARMED_MAX) begin
                armed_nxt = armed_r + 16'd1;
              end
              // Arm on a strong beat, or on any beat after enough eligible frames.
              if (item_r.big_beat || (armed_nxt >= 16'(PATIENCE) && beat)) begin
                armed_nxt = 16'd0;
                phase_nxt = PH_NOD;
                runb_nxt  = 16'd0;
                runf_nxt  = 9'd0;
                runt_nxt  = 9'(MIN_RUN) + run_rem;
                total_nxt = total_r + 32'd1;
                lfsr_nxt  = lfsr_step;
              end
            end
          end else begin
            runf_nxt = runf_r + 9'd1;
            if (beat) begin
              runb_nxt = runb_r + 16'd1;
            end
            if (phase_r == PH_NOD && runf_nxt >= runt_r) begin
              phase_nxt = PH_FINISH;
            end
            if (phase_nxt == PH_FINISH &&
                (item_r.target_angle <= 10'(PARK_ANGLE) ||
                 {1'b0, runf_nxt} >= {1'b0, runt_r} + 10'(END_GRACE))) begin
              phase_nxt = PH_WAIT;
              wait_nxt  = 9'(WAIT_MIN) + wait_rem;
              lfsr_nxt  = lfsr_step;
            end
          end
        end

        follow = (mode_r == MODE_ALWAYS) ||
                 (mode_r == MODE_AUTO && phase_nxt != PH_WAIT);
        if (follow) begin
          pos_nxt    = map_pos;
          parked_nxt = 1'b0;
          write      = 1'b1;
        end else if (!parked_r) begin
          pos_nxt    = 8'sd0;
          parked_nxt = 1'b1;
          write      = 1'b1;
        end
      end
    end

    // Mode write restarts the sequencer and parks silently unless the new mode is always.
    if (cfg_we && cfg_index == REG_NOD_MODE) begin
      phase_nxt = PH_WAIT;
      wait_nxt  = 9'd0;
      if (cfg_mode != MODE_ALWAYS) begin
        pos_nxt    = 8'sd0;
        parked_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_nxt.servo_write   = write;
    out_nxt.neck_position = pos_nxt;
    out_nxt.bass_strength = bs;
    out_nxt.full_strength = fs;
    out_nxt.loudness      = (item_r.func == FUNC_TICK) ? 14'd0 : loud_r;
    case (phase_nxt)
      PH_NOD:    out_nxt.burst_state = BS_NODDING;
      PH_FINISH: out_nxt.burst_state = BS_FINISHING;
      default:   out_nxt.burst_state = BS_WAITING;
    endcase
    out_nxt.frames_into_burst = runf_nxt;
    out_nxt.burst_length      = runt_nxt;
    out_nxt.frames_to_wait    = wait_nxt;
    out_nxt.beats_in_burst    = runb_nxt;
    out_nxt.peak_confidence   = peak_nxt;
    out_nxt.bursts_started    = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_OFF;
      floor_r <= FLOOR_RESET;
      idle_r  <= IDLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NOD_MODE:   mode_r  <= cfg_mode;
        REG_CONF_FLOOR: floor_r <= cfg_floor;
        REG_IDLE_PARK:  idle_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r   <= LFSR_SEED;
      phase_r  <= PH_WAIT;
      wait_r   <= 9'd0;
      armed_r  <= 16'd0;
      runf_r   <= 9'd0;
      runt_r   <= 9'd0;
      runb_r   <= 16'd0;
      total_r  <= 32'd0;
      peak_r   <= 7'd0;
      parked_r <= 1'b1;
      quiet_r  <= 10'd0;
      pos_r    <= 8'sd0;
    end else begin
      lfsr_r   <= lfsr_nxt;
      phase_r  <= phase_nxt;
      wait_r   <= wait_nxt;
      armed_r  <= armed_nxt;
      runf_r   <= runf_nxt;
      runt_r   <= runt_nxt;
      runb_r   <= runb_nxt;
      total_r  <= total_nxt;
      peak_r   <= peak_nxt;
      parked_r <= parked_nxt;
      quiet_r  <= quiet_nxt;
      pos_r    <= pos_nxt;
    end
  end

  `BNBS_ASSERT_IMP(a_burst_only_auto, clk, rst_n, phase_r != PH_WAIT, mode_r == MODE_AUTO, "burst running outside auto mode")
  `BNBS_ASSERT_IMP(a_parked_neutral, clk, rst_n, parked_r, pos_r == 8'sd0, "parked neck away from neutral")
  `BNBS_ASSERT_IMP(a_no_wait_in_burst, clk, rst_n, phase_r != PH_WAIT, wait_r == 9'd0, "wait count left during burst")
  `BNBS_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_vld_r && out_stall, "input stalled without a blocked result")
  `BNBS_ASSERT_NXT(a_result_follows, clk, rst_n, advance, out_vld_r, "advanced item produced no result")

endmodule

/* test/beat_nod_checker.sv */
// Checker for the beat nod burst sequencer: predicts each result from the transfers it
// sees on the input and register ports and compares it with the result channel.
// Depends on bnbs_pkg for the payload types and codes.
module beat_nod_checker
  import bnbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic        in_stall,
  input  bnbs_in_t    in_data,
  input  logic        out_vld,
  input  logic        out_stall,
  input  bnbs_out_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_wdata,
  output int          errors,
  output int          pending,
  output int          checked,
  output logic [31:0] bursts_begun
);

  localparam int ANGLE_MIN   = 170;
  localparam int ANGLE_MAX   = 800;
  localparam int NECK_SPAN   = 100;
  localparam int FRAME_RATE  = 23;
  localparam int RUN_MIN     = 10 * FRAME_RATE;
  localparam int RUN_SPREAD  = 8 * FRAME_RATE;
  localparam int GRACE       = 2 * FRAME_RATE;
  localparam int WAIT_BASE   = 8 * FRAME_RATE;
  localparam int WAIT_SPREAD = 12 * FRAME_RATE;
  localparam int PATIENCE    = 2 * FRAME_RATE;
  localparam int PARK_AT     = ANGLE_MIN + 30;
  localparam int FLOOR_TOP   = 100;
  localparam int LOUD_GAIN   = 39;

  // register copies
  logic [1:0]        mode_q;
  logic [6:0]        floor_q;
  logic [9:0]        park_ms_q;

  // sequencer copy
  logic [15:0]       lfsr_q;
  bnbs_phase_t       phase_q;
  logic [8:0]        wait_q;
  logic [15:0]       armed_q;
  logic [8:0]        run_q;
  logic [8:0]        target_q;
  logic [15:0]       beats_q;
  logic [31:0]       bursts_q;
  logic [6:0]        peak_q;
  logic              parked_q;
  logic [9:0]        quiet_q;
  logic signed [7:0] pos_q;

  bnbs_out_t         expected_q[$];
  bnbs_out_t         want;
  int                fails = 0;
  int                compared = 0;

  function automatic void reset_model();
    mode_q    = MODE_OFF;
    floor_q   = 7'd30;
    park_ms_q = 10'd750;
    lfsr_q    = 16'hBEEF;
    phase_q   = PH_WAIT;
    wait_q    = '0;
    armed_q   = '0;
    run_q     = '0;
    target_q  = '0;
    beats_q   = '0;
    bursts_q  = '0;
    peak_q    = '0;
    parked_q  = 1'b1;
    quiet_q   = '0;
    pos_q     = '0;
  endfunction

  function automatic void apply_write(input logic [1:0] idx, input logic [9:0] data);
    logic [1:0] m;
    case (idx)
      REG_NOD_MODE: begin
        m = data[1:0];
        if (m == MODE_BAD) m = MODE_OFF;
        mode_q  = m;
        phase_q = PH_WAIT;
        wait_q  = '0;
        // any mode but always drops the neck to neutral without a command
        if (m != MODE_ALWAYS) begin
          pos_q    = '0;
          parked_q = 1'b1;
        end
      end
      REG_CONF_FLOOR: floor_q = (data[6:0] > FLOOR_TOP) ? 7'(FLOOR_TOP) : data[6:0];
      REG_IDLE_PARK:  park_ms_q = data;
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] stir_lfsr(input logic [15:0] cur, input logic [7:0] energy);
    logic [15:0] v;
    logic        fb;
    v = cur ^ {8'd0, energy};
    if (v == 16'd0) v = 16'hBEEF;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[15:1]};
  endfunction

  function automatic logic signed [7:0] angle_to_pos(input logic [9:0] angle);
    int a;
    int p;
    a = angle;
    if (a < ANGLE_MIN) a = ANGLE_MIN;
    if (a > ANGLE_MAX) a = ANGLE_MAX;
    p = -(((a - ANGLE_MIN) * NECK_SPAN) / (ANGLE_MAX - ANGLE_MIN));
    return p[7:0];
  endfunction

  // Auto-mode wait/nod/finish machine for one frame.
  function automatic void advance_burst(input logic [1:0] beat, input bnbs_in_t it);
    if (it.confidence > peak_q) peak_q = it.confidence;
    if (phase_q == PH_WAIT) begin
      if (wait_q != 0) begin
        wait_q--;
        armed_q = '0;
      end else if (it.confidence < floor_q) begin
        armed_q = '0;
      end else begin
        if (armed_q != 16'hFFFF) armed_q++;
        if (it.big_beat || (armed_q >= PATIENCE && beat != STR_NONE)) begin
          armed_q  = '0;
          phase_q  = PH_NOD;
          beats_q  = '0;
          run_q    = '0;
          lfsr_q   = stir_lfsr(lfsr_q, it.energy);
          target_q = 9'(RUN_MIN + int'(lfsr_q) % RUN_SPREAD);
          bursts_q++;
        end
      end
    end else begin
      run_q++;
      if (beat != STR_NONE) beats_q++;
      if (phase_q == PH_NOD && run_q >= target_q) phase_q = PH_FINISH;
      if (phase_q == PH_FINISH &&
          (int'(it.target_angle) <= PARK_AT || int'(run_q) >= int'(target_q) + GRACE)) begin
        phase_q = PH_WAIT;
        lfsr_q  = stir_lfsr(lfsr_q, it.energy);
        wait_q  = 9'(WAIT_BASE + int'(lfsr_q) % WAIT_SPREAD);
      end
    end
  endfunction

  function automatic bnbs_out_t predict_result(input bnbs_in_t it);
    bnbs_out_t r;
    logic      follow;
    r = '0;
    if (it.func == FUNC_TICK) begin
      if (quiet_q != 10'd1023) quiet_q++;
      if (mode_q != MODE_OFF && !parked_q && quiet_q >= park_ms_q) begin
        pos_q         = '0;
        parked_q      = 1'b1;
        r.servo_write = 1'b1;
        phase_q       = PH_WAIT;
        wait_q        = '0;
      end
    end else begin
      quiet_q         = '0;
      r.bass_strength = it.bass_onset ? (it.big_beat ? STR_STRONG : STR_ONSET) : STR_NONE;
      r.full_strength = it.mid_onset ? (it.big_beat ? STR_STRONG : STR_ONSET) : STR_NONE;
      r.loudness      = 14'(int'(it.energy) * LOUD_GAIN);
      if (mode_q == MODE_AUTO)
        advance_burst(it.full_band_wins ? r.full_strength : r.bass_strength, it);
      follow = (mode_q == MODE_ALWAYS) || (mode_q == MODE_AUTO && phase_q != PH_WAIT);
      if (follow) begin
        pos_q         = angle_to_pos(it.target_angle);
        parked_q      = 1'b0;
        r.servo_write = 1'b1;
      end else if (!parked_q) begin
        pos_q         = '0;
        parked_q      = 1'b1;
        r.servo_write = 1'b1;
      end
    end
    r.neck_position = pos_q;
    case (phase_q)
      PH_NOD:    r.burst_state = BS_NODDING;
      PH_FINISH: r.burst_state = BS_FINISHING;
      default:   r.burst_state = BS_WAITING;
    endcase
    r.frames_into_burst = run_q;
    r.burst_length      = target_q;
    r.frames_to_wait    = wait_q;
    r.beats_in_burst    = beats_q;
    r.peak_confidence   = peak_q;
    r.bursts_started    = bursts_q;
    return r;
  endfunction

  function automatic void match_field(input string name, input logic signed [32:0] e,
                                      input logic signed [32:0] a);
    if (a !== e) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
      expected_q.delete();
    end else begin
      if (out_vld && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fails++;
        end else begin
          want = expected_q.pop_front();
          compared++;
          match_field("servo_write", want.servo_write, out_data.servo_write);
          match_field("neck_position", want.neck_position, out_data.neck_position);
          match_field("bass_strength", want.bass_strength, out_data.bass_strength);
          match_field("full_strength", want.full_strength, out_data.full_strength);
          match_field("loudness", want.loudness, out_data.loudness);
          match_field("burst_state", want.burst_state, out_data.burst_state);
          match_field("frames_into_burst", want.frames_into_burst,
                      out_data.frames_into_burst);
          match_field("burst_length", want.burst_length, out_data.burst_length);
          match_field("frames_to_wait", want.frames_to_wait, out_data.frames_to_wait);
          match_field("beats_in_burst", want.beats_in_burst, out_data.beats_in_burst);
          match_field("peak_confidence", want.peak_confidence, out_data.peak_confidence);
          match_field("bursts_started", want.bursts_started, out_data.bursts_started);
        end
      end
      if (cfg_we) apply_write(cfg_index, cfg_wdata);
      if (in_vld && !in_stall) expected_q.push_back(predict_result(in_data));
    end
    errors       <= fails;
    pending      <= expected_q.size();
    checked      <= compared;
    bursts_begun <= bursts_q;
  end

endmodule

/* test/beat_nod_burst_sequencer_test.sv */
// Top of the beat nod burst sequencer test: clock, reset, frame and tick stimulus,
// register writes and receiver stalls; beat_nod_checker predicts and compares.
// Depends on bnbs_pkg, beat_nod_burst_sequencer and beat_nod_checker.
module beat_nod_burst_sequencer_test;
  import bnbs_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_EVERY_THIRD} stall_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_vld = 1'b0;
  logic        in_stall;
  bnbs_in_t    in_data = '0;
  logic        out_vld;
  logic        out_stall = 1'b0;
  bnbs_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [9:0]  cfg_wdata = '0;

  int          errors;
  int          pending;
  int          checked;
  logic [31:0] bursts_begun;

  int           burst_left = 0;
  int           frames_sent = 0;
  int           ticks_sent = 0;
  int           writes_done = 0;
  stall_style_t stall_style = STALL_NONE;
  int           style_left = 0;
  int           stall_run = 0;
  int           stall_tick = 0;

  beat_nod_burst_sequencer DUT (.*);

  beat_nod_checker watch (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (in_vld),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_vld      (out_vld),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .errors       (errors),
    .pending      (pending),
    .checked      (checked),
    .bursts_begun (bursts_begun)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver: switch between random stall styles, cap any stall run.
  always @(negedge clk) begin
    logic hold;
    if (style_left == 0) begin
      stall_style = stall_style_t'($urandom_range(3, 0));
      style_left  = $urandom_range(200, 30);
    end
    style_left--;
    stall_tick++;
    case (stall_style)
      STALL_LIGHT:       hold = ($urandom_range(3, 0) == 0);
      STALL_HEAVY:       hold = ($urandom_range(3, 0) != 0);
      STALL_EVERY_THIRD: hold = (stall_tick % 3 != 0);
      default:           hold = 1'b0;
    endcase
    if (hold && stall_run >= 20) hold = 1'b0;
    stall_run = hold ? stall_run + 1 : 0;
    out_stall <= hold;
  end

  // Hold valid across a burst; drop it only for a gap between bursts.
  task automatic send_item(input bnbs_in_t item);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap != 0) begin
        in_vld <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_vld  <= 1'b1;
    in_data <= item;
    if (item.func == FUNC_TICK) ticks_sent++;
    else frames_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    @(negedge clk);
    in_vld <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    writes_done++;
  endtask

  function automatic bnbs_in_t frame_of(input logic [7:0] energy, input logic bass,
                                        input logic mid, input logic big,
                                        input logic [6:0] conf, input logic full,
                                        input logic [9:0] angle);
    bnbs_in_t it;
    it.func           = FUNC_FRAME;
    it.energy         = energy;
    it.bass_onset     = bass;
    it.mid_onset      = mid;
    it.big_beat       = big;
    it.confidence     = conf;
    it.full_band_wins = full;
    it.target_angle   = angle;
    return it;
  endfunction

  function automatic bnbs_in_t random_item(input int tick_pct, input int big_pct,
                                           input int conf_lo, input int low_angle_pct);
    bnbs_in_t it;
    it.func           = ($urandom_range(99, 0) < tick_pct) ? FUNC_TICK : FUNC_FRAME;
    it.energy         = $urandom_range(255, 0);
    it.bass_onset     = $urandom_range(1, 0);
    it.mid_onset      = $urandom_range(1, 0);
    it.big_beat       = ($urandom_range(99, 0) < big_pct);
    it.confidence     = ($urandom_range(9, 0) == 0) ? $urandom_range(127, 101)
                                                    : $urandom_range(100, conf_lo);
    it.full_band_wins = $urandom_range(1, 0);
    it.target_angle   = ($urandom_range(99, 0) < low_angle_pct) ? $urandom_range(200, 0)
                                                                : $urandom_range(1023, 201);
    return it;
  endfunction

  function automatic bnbs_in_t tick_of();
    bnbs_in_t it;
    it = random_item(100, 50, 0, 50);
    return it;
  endfunction

  // Program all three registers, then stream random items with the given mix.
  task automatic run_phase(input logic [1:0] mode, input logic [6:0] floor_val,
                           input logic [9:0] park_ms, input int count, input int tick_pct,
                           input int big_pct, input int conf_lo, input int low_angle_pct);
    settle();
    write_reg(REG_NOD_MODE, {8'($urandom), mode});
    write_reg(REG_CONF_FLOOR, {3'($urandom), floor_val});
    write_reg(REG_IDLE_PARK, park_ms);
    repeat (count) send_item(random_item(tick_pct, big_pct, conf_lo, low_angle_pct));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults after reset: neck off, nothing commanded
    send_item(frame_of(8'd0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 10'd0));
    send_item(frame_of(8'd255, 1'b1, 1'b1, 1'b1, 7'd127, 1'b1, 10'd1023));
    send_item(tick_of());

    settle();
    write_reg(REG_NOD_MODE, {8'd0, MODE_ALWAYS});
    write_reg(REG_IDLE_PARK, 10'd2);
    write_reg(REG_CONF_FLOOR, 10'd127);
    write_reg(REG_UNUSED, 10'h3FF);

    // angle clamps and mapping, nine flag combinations
    send_item(frame_of(8'd0, 1'b1, 1'b0, 1'b0, 7'd10, 1'b0, 10'd0));
    send_item(frame_of(8'd1, 1'b0, 1'b1, 1'b0, 7'd100, 1'b1, 10'd169));
    send_item(frame_of(8'd128, 1'b1, 1'b1, 1'b1, 7'd101, 1'b0, 10'd170));
    send_item(frame_of(8'd255, 1'b0, 1'b0, 1'b1, 7'd50, 1'b1, 10'd171));
    send_item(frame_of(8'd77, 1'b1, 1'b0, 1'b1, 7'd0, 1'b1, 10'd485));
    send_item(frame_of(8'd200, 1'b0, 1'b1, 1'b1, 7'd127, 1'b0, 10'd799));
    send_item(frame_of(8'd15, 1'b1, 1'b1, 1'b0, 7'd99, 1'b0, 10'd800));
    send_item(frame_of(8'd240, 1'b0, 1'b0, 1'b0, 7'd1, 1'b1, 10'd801));
    send_item(frame_of(8'd255, 1'b1, 1'b1, 1'b1, 7'd100, 1'b1, 10'd1023));
    // quiet ticks: the second one parks, the third changes nothing
    send_item(tick_of());
    send_item(tick_of());
    send_item(tick_of());
    send_item(frame_of(8'd90, 1'b0, 1'b0, 1'b0, 7'd40, 1'b0, 10'd600));

    settle();
    write_reg(REG_NOD_MODE, {8'hFF, MODE_AUTO});
    write_reg(REG_CONF_FLOOR, 10'd0);
    write_reg(REG_IDLE_PARK, 10'd1);
    // strong beat arms at once, then a low angle while nodding, then a parking tick
    send_item(frame_of(8'd33, 1'b1, 1'b0, 1'b1, 7'd0, 1'b0, 10'd500));
    send_item(frame_of(8'd66, 1'b0, 1'b1, 1'b0, 7'd20, 1'b1, 10'd100));
    send_item(tick_of());
    send_item(frame_of(8'd99, 1'b1, 1'b1, 1'b0, 7'd60, 1'b1, 10'd700));

    run_phase(MODE_ALWAYS, 7'd0, 10'd3, 40, 30, 20, 0, 20);
    run_phase(MODE_AUTO, 7'd30, 10'd1023, 300, 2, 2, 20, 15);
    run_phase(MODE_AUTO, 7'd100, 10'd1, 60, 25, 10, 60, 30);
    run_phase(MODE_OFF, 7'd127, 10'd512, 30, 30, 30, 0, 30);
    run_phase(MODE_BAD, 7'd50, 10'd1, 20, 40, 30, 0, 30);
    run_phase(MODE_AUTO, 7'd0, 10'd1023, 330, 1, 8, 0, 3);
    // switch to always while a burst may still be running
    run_phase(MODE_ALWAYS, 7'd80, 10'd5, 20, 20, 20, 0, 20);
    settle();

    $display("Drove %0d frames and %0d ticks with %0d register writes.",
             frames_sent, ticks_sent, writes_done);
    $display("Compared %0d results; the sequencer began %0d bursts.", checked, bursts_begun);
    if (errors == 0 && pending == 0) begin
      $display("beat_nod_burst_sequencer test passed");
    end else begin
      $display("beat_nod_burst_sequencer test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timed out with %0d results outstanding.", pending);
    $display("beat_nod_burst_sequencer test failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/bnbs_pkg.sv
rtl/core/beat_nod_burst_sequencer.sv
test/beat_nod_checker.sv
test/beat_nod_burst_sequencer_test.sv
